// ===== rtl/rbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types, register indexes and the CRC-16/XMODEM byte update for the
// radio bit deframer.
// ----------------------------------------------------------------------------
package rbd_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NODE_ID         = 3'd0,
        CFG_BROADCAST_ID    = 3'd1,
        CFG_SYNC_FIRST      = 3'd2,
        CFG_SYNC_SECOND     = 3'd3,
        CFG_PREAMBLE_NEEDED = 3'd4,
        CFG_SYNC_WINDOW     = 3'd5
    } cfg_index_t;

    localparam logic [7:0] NODE_ID_RESET         = 8'd0;
    localparam logic [7:0] BROADCAST_ID_RESET    = 8'd255;
    localparam logic [7:0] SYNC_FIRST_RESET      = 8'h33;
    localparam logic [7:0] SYNC_SECOND_RESET     = 8'hCC;
    localparam logic [7:0] PREAMBLE_NEEDED_RESET = 8'd16;
    localparam logic [7:0] SYNC_WINDOW_RESET     = 8'd24;

    localparam logic [7:0]  LAST_BIT  = 8'd7;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'h0000;

    typedef struct packed {
        logic       clear;
        logic       update;
        logic       capture_low;
        logic [7:0] data;
    } crc_ctrl_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/rbd_crc_unit.sv =====
// ----------------------------------------------------------------------------
// rbd_crc_unit
// Running CRC-16/XMODEM over the frame header and payload, plus the holding
// register for the first (low) received CRC byte.
// ----------------------------------------------------------------------------
module rbd_crc_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  rbd_pkg::crc_ctrl_t ctrl,
    output logic [15:0]       crc,
    output logic [7:0]        crc_low
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  crc_low_reg;
    logic [7:0]  crc_low_next;

    always_comb
    begin
        crc_next     = crc_reg;
        crc_low_next = crc_low_reg;
        if (ctrl.clear)
        begin
            crc_next     = rbd_pkg::CRC_INIT;
            crc_low_next = 8'd0;
        end
        else
        begin
            if (ctrl.update)
            begin
                crc_next = rbd_pkg::crc16_byte(crc_reg, ctrl.data);
            end
            if (ctrl.capture_low)
            begin
                crc_low_next = ctrl.data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= rbd_pkg::CRC_INIT;
            crc_low_reg <= 8'd0;
        end
        else
        begin
            crc_reg     <= crc_next;
            crc_low_reg <= crc_low_next;
        end
    end

    assign crc     = crc_reg;
    assign crc_low = crc_low_reg;

endmodule

// ===== rtl/radio_bit_deframer.sv =====
// ----------------------------------------------------------------------------
// radio_bit_deframer
// Preamble hunt, two-byte sync search and frame byte assembly with a
// CRC-16/XMODEM check and destination filter, one received bit per beat.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while in_ready is high, and returns
// exactly one registered result beat for every input beat, in the cycle after
// it is accepted. The state update and the byte-wide CRC step sit between the
// state registers and the result register, so throughput is one beat per cycle
// whenever the result side takes its beats; the result register lets a new beat
// in while the last result is taken in the same cycle. Configuration writes land
// at once and should be made while no beat is in flight.
module radio_bit_deframer #(
    parameter int unsigned FRAME_CAPACITY = 64,
    parameter int unsigned HEADER_BYTES   = 5,
    parameter int unsigned LENGTH_POS     = 4,
    parameter int unsigned DEST_POS       = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rbd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic                              bit_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              sync_found,
    output logic                              byte_valid,
    output logic [7:0]                        byte_value,
    output logic [7:0]                        byte_index,
    output logic                              frame_done,
    output logic                              crc_ok,
    output logic                              for_this_node,
    output logic                              overflow
);

    localparam logic [7:0] CAPACITY = 8'(FRAME_CAPACITY);
    localparam logic [7:0] LEN_POS  = 8'(LENGTH_POS);
    localparam logic [7:0] DST_POS  = 8'(DEST_POS);
    localparam logic [9:0] HDR      = 10'(HEADER_BYTES);

    typedef enum logic [2:0] {
        PH_PREAMBLE,
        PH_SOF1,
        PH_SOF2,
        PH_SYNC,
        PH_DONE
    } phase_t;

    logic [7:0] node_id_reg;
    logic [7:0] broadcast_id_reg;
    logic [7:0] sync_first_reg;
    logic [7:0] sync_second_reg;
    logic [7:0] preamble_needed_reg;
    logic [7:0] sync_window_reg;

    phase_t     phase_reg, phase_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] bit_count_reg, bit_count_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] length_reg, length_next;
    logic [7:0] dest_reg, dest_next;

    logic       out_valid_reg, out_valid_next;
    logic       sync_found_reg, sync_found_next;
    logic       byte_valid_reg, byte_valid_next;
    logic [7:0] byte_value_reg, byte_value_next;
    logic [7:0] byte_index_reg, byte_index_next;
    logic       frame_done_reg, frame_done_next;
    logic       crc_ok_reg, crc_ok_next;
    logic       for_node_reg, for_node_next;
    logic       overflow_reg, overflow_next;

    rbd_pkg::crc_ctrl_t crc_ctrl;
    logic [15:0]        crc_value;
    logic [7:0]         crc_low_value;

    logic       accept;
    logic [7:0] shifted;
    logic [9:0] body;
    logic [9:0] bp_wide;

    rbd_crc_unit u_crc (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (crc_ctrl),
        .crc     (crc_value),
        .crc_low (crc_low_value)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign shifted  = {shift_reg[6:0], bit_value};
    assign bp_wide  = {2'b00, byte_count_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        shift_next      = shift_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        length_next     = length_reg;
        dest_next       = dest_reg;
        sync_found_next = 1'b0;
        byte_valid_next = 1'b0;
        byte_value_next = 8'd0;
        byte_index_next = 8'd0;
        frame_done_next = 1'b0;
        crc_ok_next     = 1'b0;
        for_node_next   = 1'b0;
        overflow_next   = 1'b0;
        crc_ctrl        = '0;
        crc_ctrl.data   = shifted;
        body            = HDR + {2'b00, length_reg};

        if (accept)
        begin
            if (mode)
            begin
                phase_next      = PH_PREAMBLE;
                bit_count_next  = preamble_needed_reg;
                byte_count_next = 8'd0;
            end
            else if (phase_reg != PH_DONE)
            begin
                shift_next = shifted;
                unique case (phase_reg)
                    PH_PREAMBLE:
                    begin
                        if (bit_count_reg != 8'd0)
                        begin
                            if (shifted[0] ^ shifted[1])
                            begin
                                bit_count_next = bit_count_reg - 8'd1;
                            end
                            else
                            begin
                                bit_count_next = preamble_needed_reg;
                            end
                        end
                        else
                        begin
                            phase_next     = PH_SOF1;
                            bit_count_next = sync_window_reg;
                        end
                    end
                    PH_SOF1:
                    begin
                        if (shifted == sync_first_reg)
                        begin
                            phase_next     = PH_SOF2;
                            bit_count_next = 8'd0;
                        end
                        else if (bit_count_reg == 8'd0)
                        begin
                            phase_next      = PH_PREAMBLE;
                            bit_count_next  = preamble_needed_reg;
                            byte_count_next = 8'd0;
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg - 8'd1;
                        end
                    end
                    PH_SOF2:
                    begin
                        if (bit_count_reg == rbd_pkg::LAST_BIT)
                        begin
                            if (shifted == sync_second_reg)
                            begin
                                phase_next      = PH_SYNC;
                                bit_count_next  = 8'd0;
                                byte_count_next = 8'd0;
                                length_next     = 8'd0;
                                dest_next       = 8'd0;
                                crc_ctrl.clear  = 1'b1;
                                sync_found_next = 1'b1;
                            end
                            else
                            begin
                                phase_next      = PH_PREAMBLE;
                                bit_count_next  = preamble_needed_reg;
                                byte_count_next = 8'd0;
                            end
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg + 8'd1;
                        end
                    end
                    PH_SYNC:
                    begin
                        if (bit_count_reg == rbd_pkg::LAST_BIT)
                        begin
                            bit_count_next = 8'd0;
                            if (byte_count_reg >= CAPACITY)
                            begin
                                overflow_next   = 1'b1;
                                phase_next      = PH_PREAMBLE;
                                bit_count_next  = preamble_needed_reg;
                                byte_count_next = 8'd0;
                            end
                            else
                            begin
                                byte_valid_next = 1'b1;
                                byte_value_next = shifted;
                                byte_index_next = byte_count_reg;
                                if (byte_count_reg == LEN_POS)
                                begin
                                    length_next = shifted;
                                end
                                if (byte_count_reg == DST_POS)
                                begin
                                    dest_next = shifted;
                                end
                                body = HDR + {2'b00, length_next};
                                if (bp_wide < body)
                                begin
                                    crc_ctrl.update = 1'b1;
                                end
                                else if (bp_wide == body)
                                begin
                                    crc_ctrl.capture_low = 1'b1;
                                end
                                if ((bp_wide > HDR) && (bp_wide == body + 10'd1))
                                begin
                                    frame_done_next = 1'b1;
                                    crc_ok_next = ({shifted, crc_low_value} == crc_value);
                                    for_node_next = (dest_next == node_id_reg)
                                        || (dest_next == broadcast_id_reg);
                                    phase_next = PH_DONE;
                                end
                                byte_count_next = byte_count_reg + 8'd1;
                            end
                        end
                        else
                        begin
                            bit_count_next = bit_count_reg + 8'd1;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        out_valid_next = out_valid_reg && !out_ready;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg         <= rbd_pkg::NODE_ID_RESET;
            broadcast_id_reg    <= rbd_pkg::BROADCAST_ID_RESET;
            sync_first_reg      <= rbd_pkg::SYNC_FIRST_RESET;
            sync_second_reg     <= rbd_pkg::SYNC_SECOND_RESET;
            preamble_needed_reg <= rbd_pkg::PREAMBLE_NEEDED_RESET;
            sync_window_reg     <= rbd_pkg::SYNC_WINDOW_RESET;
            phase_reg           <= PH_PREAMBLE;
            shift_reg           <= 8'd0;
            bit_count_reg       <= rbd_pkg::PREAMBLE_NEEDED_RESET;
            byte_count_reg      <= 8'd0;
            length_reg          <= 8'd0;
            dest_reg            <= 8'd0;
            out_valid_reg       <= 1'b0;
            sync_found_reg      <= 1'b0;
            byte_valid_reg      <= 1'b0;
            byte_value_reg      <= 8'd0;
            byte_index_reg      <= 8'd0;
            frame_done_reg      <= 1'b0;
            crc_ok_reg          <= 1'b0;
            for_node_reg        <= 1'b0;
            overflow_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (rbd_pkg::cfg_index_t'(cfg_index))
                    rbd_pkg::CFG_NODE_ID:         node_id_reg         <= cfg_data;
                    rbd_pkg::CFG_BROADCAST_ID:    broadcast_id_reg    <= cfg_data;
                    rbd_pkg::CFG_SYNC_FIRST:      sync_first_reg      <= cfg_data;
                    rbd_pkg::CFG_SYNC_SECOND:     sync_second_reg     <= cfg_data;
                    rbd_pkg::CFG_PREAMBLE_NEEDED: preamble_needed_reg <= cfg_data;
                    rbd_pkg::CFG_SYNC_WINDOW:     sync_window_reg     <= cfg_data;
                    default:
                    begin
                        node_id_reg <= node_id_reg;
                    end
                endcase
            end
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            bit_count_reg  <= bit_count_next;
            byte_count_reg <= byte_count_next;
            length_reg     <= length_next;
            dest_reg       <= dest_next;
            out_valid_reg  <= out_valid_next;
            if (accept)
            begin
                sync_found_reg <= sync_found_next;
                byte_valid_reg <= byte_valid_next;
                byte_value_reg <= byte_value_next;
                byte_index_reg <= byte_index_next;
                frame_done_reg <= frame_done_next;
                crc_ok_reg     <= crc_ok_next;
                for_node_reg   <= for_node_next;
                overflow_reg   <= overflow_next;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign sync_found    = sync_found_reg;
    assign byte_valid    = byte_valid_reg;
    assign byte_value    = byte_value_reg;
    assign byte_index    = byte_index_reg;
    assign frame_done    = frame_done_reg;
    assign crc_ok        = crc_ok_reg;
    assign for_this_node = for_node_reg;
    assign overflow      = overflow_reg;

endmodule

// ===== tb/radio_bit_deframer_test.sv =====
// ----------------------------------------------------------------------------
// radio_bit_deframer_test
// Self-checking bench for the radio bit deframer. Received bits are streamed
// in as preambles, sync bytes and CRC-protected frames, mixed with line noise,
// broken sync words, early rearms and over-long frames. Every result beat is
// compared field by field against a cycle-free model of the hunt, sync and
// frame logic, across four register settings and four handshake pressures.
// ----------------------------------------------------------------------------
module radio_bit_deframer_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_CAPACITY = 64;
    localparam int unsigned HEADER_BYTES   = 5;
    localparam int unsigned LENGTH_POS     = 4;
    localparam int unsigned DEST_POS       = 3;
    localparam int unsigned PHASE_COUNT    = 4;
    localparam int unsigned PHASE_BEATS    = 100;
    localparam int unsigned LIMIT_CYCLES   = 400000;

    typedef enum logic [2:0] {
        RX_PREAMBLE,
        RX_SYNC1,
        RX_SYNC2,
        RX_BODY,
        RX_DONE
    } rx_state_t;

    typedef struct packed {
        logic rearm;
        logic level;
    } beat_t;

    typedef struct packed {
        logic       sync_found;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic       frame_done;
        logic       crc_ok;
        logic       for_this_node;
        logic       overflow;
    } rx_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [rbd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rbd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic                            mode = 1'b0;
    logic                            bit_value = 1'b0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            sync_found;
    logic                            byte_valid;
    logic [7:0]                      byte_value;
    logic [7:0]                      byte_index;
    logic                            frame_done;
    logic                            crc_ok;
    logic                            for_this_node;
    logic                            overflow;

    beat_t       pending_bits[$];
    rx_result_t  predicted_results[$];
    beat_t       next_beat;
    rx_result_t  seen;

    logic [7:0]  cfg_node;
    logic [7:0]  cfg_bcast;
    logic [7:0]  cfg_sync1;
    logic [7:0]  cfg_sync2;
    logic [7:0]  cfg_pre;
    logic [7:0]  cfg_win;

    rx_state_t   rx_state;
    logic [7:0]  shift_reg;
    logic [7:0]  bit_cnt;
    logic [7:0]  byte_cnt;
    logic [7:0]  len_byte;
    logic [7:0]  dst_byte;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned idle_send[4] = '{0, 62, 0, 21};
    int unsigned idle_stall[4] = '{0, 0, 62, 21};
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;
    int unsigned beats_seen = 0;
    int unsigned bytes_seen = 0;
    int unsigned syncs_seen = 0;
    int unsigned frames_seen = 0;
    int unsigned good_crcs = 0;
    int unsigned addressed = 0;
    int unsigned overflows = 0;

    radio_bit_deframer #(
        .FRAME_CAPACITY(FRAME_CAPACITY),
        .HEADER_BYTES  (HEADER_BYTES),
        .LENGTH_POS    (LENGTH_POS),
        .DEST_POS      (DEST_POS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .bit_value    (bit_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sync_found   (sync_found),
        .byte_valid   (byte_valid),
        .byte_value   (byte_value),
        .byte_index   (byte_index),
        .frame_done   (frame_done),
        .crc_ok       (crc_ok),
        .for_this_node(for_this_node),
        .overflow     (overflow)
    );

    always #10 clk = ~clk;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb  = acc[15] ^ data[k];
            acc = {acc[14:0], 1'b0};
            if (fb)
            begin
                acc = acc ^ rbd_pkg::CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void restart_hunt();
        rx_state = RX_PREAMBLE;
        bit_cnt  = cfg_pre;
        byte_cnt = 8'd0;
    endfunction

    function automatic void reset_model();
        cfg_node  = rbd_pkg::NODE_ID_RESET;
        cfg_bcast = rbd_pkg::BROADCAST_ID_RESET;
        cfg_sync1 = rbd_pkg::SYNC_FIRST_RESET;
        cfg_sync2 = rbd_pkg::SYNC_SECOND_RESET;
        cfg_pre   = rbd_pkg::PREAMBLE_NEEDED_RESET;
        cfg_win   = rbd_pkg::SYNC_WINDOW_RESET;
        shift_reg = 8'd0;
        len_byte  = 8'd0;
        dst_byte  = 8'd0;
        crc_acc   = rbd_pkg::CRC_INIT;
        crc_lo    = 8'd0;
        restart_hunt();
    endfunction

    function automatic rx_result_t deframe_bit(input logic rearm, input logic level);
        rx_result_t  r;
        int unsigned pos;
        int unsigned body;
        r = '0;
        if (rearm)
        begin
            restart_hunt();
            return r;
        end
        if (rx_state == RX_DONE)
        begin
            return r;
        end
        shift_reg = {shift_reg[6:0], level};
        case (rx_state)
            RX_PREAMBLE:
            begin
                if (bit_cnt != 8'd0)
                begin
                    if (shift_reg[0] != shift_reg[1])
                    begin
                        bit_cnt = bit_cnt - 8'd1;
                    end
                    else
                    begin
                        bit_cnt = cfg_pre;
                    end
                end
                else
                begin
                    rx_state = RX_SYNC1;
                    bit_cnt  = cfg_win;
                end
            end
            RX_SYNC1:
            begin
                if (shift_reg == cfg_sync1)
                begin
                    rx_state = RX_SYNC2;
                    bit_cnt  = 8'd0;
                end
                else if (bit_cnt == 8'd0)
                begin
                    restart_hunt();
                end
                else
                begin
                    bit_cnt = bit_cnt - 8'd1;
                end
            end
            RX_SYNC2:
            begin
                if (bit_cnt == rbd_pkg::LAST_BIT)
                begin
                    if (shift_reg == cfg_sync2)
                    begin
                        rx_state     = RX_BODY;
                        bit_cnt      = 8'd0;
                        byte_cnt     = 8'd0;
                        len_byte     = 8'd0;
                        dst_byte     = 8'd0;
                        crc_acc      = rbd_pkg::CRC_INIT;
                        crc_lo       = 8'd0;
                        r.sync_found = 1'b1;
                    end
                    else
                    begin
                        restart_hunt();
                    end
                end
                else
                begin
                    bit_cnt = bit_cnt + 8'd1;
                end
            end
            default:
            begin
                if (bit_cnt == rbd_pkg::LAST_BIT)
                begin
                    pos     = byte_cnt;
                    bit_cnt = 8'd0;
                    if (pos >= FRAME_CAPACITY)
                    begin
                        r.overflow = 1'b1;
                        restart_hunt();
                    end
                    else
                    begin
                        r.byte_valid = 1'b1;
                        r.byte_value = shift_reg;
                        r.byte_index = pos[7:0];
                        if (pos == LENGTH_POS)
                        begin
                            len_byte = shift_reg;
                        end
                        if (pos == DEST_POS)
                        begin
                            dst_byte = shift_reg;
                        end
                        body = HEADER_BYTES + len_byte;
                        if (pos < body)
                        begin
                            crc_acc = crc16_update(crc_acc, shift_reg);
                        end
                        else if (pos == body)
                        begin
                            crc_lo = shift_reg;
                        end
                        if (pos > HEADER_BYTES && pos == body + 1)
                        begin
                            r.frame_done    = 1'b1;
                            r.crc_ok        = ({shift_reg, crc_lo} == crc_acc);
                            r.for_this_node = (dst_byte == cfg_node) || (dst_byte == cfg_bcast);
                            rx_state        = RX_DONE;
                        end
                        byte_cnt = 8'(pos + 1);
                    end
                end
                else
                begin
                    bit_cnt = bit_cnt + 8'd1;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void push_bit(input logic rearm, input logic level);
        beat_t b;
        b.rearm = rearm;
        b.level = level;
        pending_bits.push_back(b);
    endfunction

    function automatic void push_byte(input logic [7:0] value);
        for (int k = 7; k >= 0; k--)
        begin
            push_bit(1'b0, value[k]);
        end
    endfunction

    function automatic void queue_noise();
        int unsigned n;
        n = $urandom_range(40, 8);
        repeat (n)
        begin
            push_bit($urandom_range(15) == 0, 1'($urandom_range(1)));
        end
    endfunction

    // Sends a preamble that opens with two equal bits, so the transition count
    // is known to start full, then both sync bytes and a frame. Some frames
    // carry a bad CRC, a wrong second sync byte, an early rearm or a length
    // that runs past the buffer.
    function automatic void queue_frame();
        logic [7:0]  frame_bytes[$];
        logic [7:0]  b;
        logic [15:0] crc;
        logic        level;
        int unsigned flaw;
        int unsigned lead;
        int unsigned len;
        int unsigned fill;
        int unsigned cut;
        flaw  = $urandom_range(11);
        lead  = cfg_pre + 2 + $urandom_range(3);
        level = 1'($urandom_range(1));
        crc   = rbd_pkg::CRC_INIT;
        push_bit(1'b0, level);
        for (int i = 0; i < lead; i++)
        begin
            push_bit(1'b0, level);
            level = ~level;
        end
        push_byte(cfg_sync1);
        push_byte(flaw == 1 ? ~cfg_sync2 : cfg_sync2);
        if (flaw == 3)
        begin
            len = $urandom_range(255, 58);
        end
        else if ($urandom_range(7) == 0)
        begin
            len = $urandom_range(57);
        end
        else
        begin
            len = $urandom_range(12);
        end
        fill = HEADER_BYTES + len;
        if (fill > FRAME_CAPACITY + 1)
        begin
            fill = FRAME_CAPACITY + 1;
        end
        for (int i = 0; i < fill; i++)
        begin
            b = 8'($urandom);
            if (i == DEST_POS)
            begin
                case ($urandom_range(2))
                    0: b = cfg_node;
                    1: b = cfg_bcast;
                    default: b = 8'($urandom);
                endcase
            end
            if (i == LENGTH_POS)
            begin
                b = 8'(len);
            end
            crc = crc16_update(crc, b);
            frame_bytes.push_back(b);
        end
        if (HEADER_BYTES + len + 2 <= FRAME_CAPACITY)
        begin
            if (flaw == 0)
            begin
                crc = crc ^ 16'(1 << $urandom_range(15));
            end
            frame_bytes.push_back(crc[7:0]);
            frame_bytes.push_back(crc[15:8]);
        end
        cut = (flaw == 2) ? $urandom_range(frame_bytes.size() - 1) : frame_bytes.size();
        for (int i = 0; i < cut; i++)
        begin
            push_byte(frame_bytes[i]);
        end
        repeat ($urandom_range(7))
        begin
            push_bit(1'b0, 1'($urandom_range(1)));
        end
        push_bit(1'b1, 1'($urandom_range(1)));
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic write_reg(input rbd_pkg::cfg_index_t idx, input logic [7:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            rbd_pkg::CFG_NODE_ID:         cfg_node  = value;
            rbd_pkg::CFG_BROADCAST_ID:    cfg_bcast = value;
            rbd_pkg::CFG_SYNC_FIRST:      cfg_sync1 = value;
            rbd_pkg::CFG_SYNC_SECOND:     cfg_sync2 = value;
            rbd_pkg::CFG_PREAMBLE_NEEDED: cfg_pre   = value;
            default:                      cfg_win   = value;
        endcase
    endtask

    task automatic configure(input int unsigned setting);
        logic [7:0] value[6];
        case (setting)
            0: value = '{rbd_pkg::NODE_ID_RESET, rbd_pkg::BROADCAST_ID_RESET,
                         rbd_pkg::SYNC_FIRST_RESET, rbd_pkg::SYNC_SECOND_RESET,
                         rbd_pkg::PREAMBLE_NEEDED_RESET, rbd_pkg::SYNC_WINDOW_RESET};
            1: value = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'd1, 8'd255};
            2: value = '{8'($urandom), 8'($urandom), 8'h00, 8'hFF, 8'd255, 8'd12};
            3: value = '{8'($urandom), 8'($urandom), 8'h55, 8'($urandom), 8'd8, 8'd0};
            default: value = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom_range(32, 1)), 8'($urandom_range(40, 10))};
        endcase
        for (int i = 0; i < 6; i++)
        begin
            write_reg(rbd_pkg::cfg_index_t'(i), value[i]);
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_bits.size() != 0 || in_valid || predicted_results.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predicted_results.push_back(deframe_bit(mode, bit_value));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_bits.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat = pending_bits.pop_front();
                    in_valid  <= 1'b1;
                    mode      <= next_beat.rearm;
                    bit_value <= next_beat.level;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("result beat arrived with nothing expected");
                fail_count++;
            end
            else
            begin
                seen = predicted_results.pop_front();
                check_field("sync_found", seen.sync_found, sync_found);
                check_field("byte_valid", seen.byte_valid, byte_valid);
                check_field("byte_value", seen.byte_value, byte_value);
                check_field("byte_index", seen.byte_index, byte_index);
                check_field("frame_done", seen.frame_done, frame_done);
                check_field("crc_ok", seen.crc_ok, crc_ok);
                check_field("for_this_node", seen.for_this_node, for_this_node);
                check_field("overflow", seen.overflow, overflow);
                beats_seen++;
                bytes_seen += seen.byte_valid;
                syncs_seen += seen.sync_found;
                frames_seen += seen.frame_done;
                good_crcs += seen.crc_ok;
                addressed += seen.for_this_node;
                overflows += seen.overflow;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        reset_model();
        push_bit(1'b1, 1'b0);
        push_bit(1'b1, 1'b1);
        for (int i = 0; i < 20; i++)
        begin
            push_bit(1'b0, 1'(i % 2));
        end
        push_bit(1'b1, 1'b0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait_drained();
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            configure(p);
            send_idle_pct = idle_send[p % 4];
            stall_pct     = idle_stall[p % 4];
            while (pending_bits.size() < PHASE_BEATS)
            begin
                if ($urandom_range(3) != 0)
                begin
                    queue_frame();
                end
                else
                begin
                    queue_noise();
                end
            end
            wait_drained();
        end
        repeat (8) @(posedge clk);
        if (predicted_results.size() != 0)
        begin
            $error("%0d result beats never arrived", predicted_results.size());
            fail_count++;
        end
        $display("Checked %0d bit beats over %0d register settings: %0d syncs, %0d bytes.",
                 beats_seen, PHASE_COUNT, syncs_seen, bytes_seen);
        $display("Frames completed %0d (good CRC %0d, addressed here %0d), overflows %0d.",
                 frames_seen, good_crcs, addressed, overflows);
        if (fail_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
